/* rtl/mfd_pkg.sv */
`default_nettype none

package mfd_pkg;

  localparam int unsigned DEF_INFO_BYTES  = 9;
  localparam int unsigned DEF_MAX_PAYLOAD = 65536;

  localparam int unsigned MAGIC_BYTES = 4;
  localparam int unsigned LEN_BYTES   = 4;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FLEN_W  = 17;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FLEN_W-1:0] FLEN_MAX = {FLEN_W{1'b1}};

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_MAGIC = 3'd1,
    PH_SEQ   = 3'd2,
    PH_CMD   = 3'd3,
    PH_INFO  = 3'd4,
    PH_LEN   = 3'd5,
    PH_PAY   = 3'd6,
    PH_TAIL  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    K_PAYLOAD  = 3'd0,
    K_GOOD     = 3'd1,
    K_BADTAIL  = 3'd2,
    K_BADMAGIC = 3'd3,
    K_TOOLONG  = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD  = 2'd0,
    CFG_MAGIC = 2'd1,
    CFG_TAIL  = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

/* rtl/marker_frame_deframer.sv */
`default_nettype none
// Byte-stream frame parser: one received byte per beat.
// A result is registered onto out_valid when the byte that causes it is accepted.
// Throughput: one byte per cycle; in_ready drops only while a held result is not taken.
// Reset (synchronous, rst_n low) clears the marker and magic registers to zero,
// puts the parser in the hunt phase and empties the result register.
module marker_frame_deframer #(
  parameter int unsigned INFO_BYTES  = mfd_pkg::DEF_INFO_BYTES,
  parameter int unsigned MAX_PAYLOAD = mfd_pkg::DEF_MAX_PAYLOAD
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mfd_pkg::WORD_W-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mfd_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mfd_pkg::kind_t                      out_kind,
  output logic [mfd_pkg::BYTE_W-1:0]          out_payload_byte,
  output logic [mfd_pkg::BYTE_W-1:0]          out_frame_seq,
  output logic [mfd_pkg::BYTE_W-1:0]          out_frame_cmd,
  output logic [mfd_pkg::FLEN_W-1:0]          out_frame_length
);
  import mfd_pkg::*;

  // The byte counter walks the magic, info and length fields.
  localparam int unsigned IDX_W = (INFO_BYTES > 3) ? $clog2(INFO_BYTES + 1) : 2;
  localparam int unsigned PAY_W = $clog2(MAX_PAYLOAD + 1);

  logic [BYTE_W-1:0] head_marker_r;
  logic [WORD_W-1:0] magic_word_r;
  logic [BYTE_W-1:0] tail_marker_r;

  phase_t             phase_r, phase_nxt;
  logic [IDX_W-1:0]   byte_idx_r, byte_idx_nxt;
  logic [BYTE_W-1:0]  seq_hold_r, seq_hold_nxt;
  logic [BYTE_W-1:0]  cmd_hold_r, cmd_hold_nxt;
  logic [WORD_W-1:0]  length_accum_r, length_accum_nxt;
  logic [PAY_W-1:0]   pay_left_r, pay_left_nxt;

  logic               emit;
  logic               emit_hdr;
  kind_t              emit_kind;
  logic [BYTE_W-1:0]  emit_pbyte;
  logic [FLEN_W-1:0]  len_sat;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [BYTE_W-1:0]  out_pbyte_r;
  logic [BYTE_W-1:0]  out_seq_r;
  logic [BYTE_W-1:0]  out_cmd_r;
  logic [FLEN_W-1:0]  out_len_r;

  logic               in_fire;
  logic [BYTE_W-1:0]  magic_expect;
  logic [4:0]         lane_shift;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign lane_shift   = {byte_idx_r[1:0], 3'b000};
  assign magic_expect = BYTE_W'(magic_word_r >> lane_shift);

  always_comb begin
    phase_nxt        = phase_r;
    byte_idx_nxt     = byte_idx_r;
    seq_hold_nxt     = seq_hold_r;
    cmd_hold_nxt     = cmd_hold_r;
    length_accum_nxt = length_accum_r;
    pay_left_nxt     = pay_left_r;
    emit             = 1'b0;
    emit_hdr         = 1'b1;
    emit_kind        = K_PAYLOAD;
    emit_pbyte       = '0;

    unique case (phase_r)
      PH_HUNT: begin
        if (in_rx_byte == head_marker_r) begin
          phase_nxt    = PH_MAGIC;
          byte_idx_nxt = '0;
        end
      end
      PH_MAGIC: begin
        if (in_rx_byte == magic_expect) begin
          if (byte_idx_r == IDX_W'(MAGIC_BYTES - 1)) begin
            phase_nxt    = PH_SEQ;
            byte_idx_nxt = '0;
          end else begin
            byte_idx_nxt = byte_idx_r + 1'b1;
          end
        end else begin
          // A mismatching byte that is itself a head marker opens a new frame.
          byte_idx_nxt = '0;
          phase_nxt    = (in_rx_byte == head_marker_r) ? PH_MAGIC : PH_HUNT;
          emit         = 1'b1;
          emit_hdr     = 1'b0;
          emit_kind    = K_BADMAGIC;
        end
      end
      PH_SEQ: begin
        seq_hold_nxt = in_rx_byte;
        phase_nxt    = PH_CMD;
      end
      PH_CMD: begin
        cmd_hold_nxt = in_rx_byte;
        byte_idx_nxt = '0;
        if (INFO_BYTES == 0) begin
          phase_nxt        = PH_LEN;
          length_accum_nxt = '0;
        end else begin
          phase_nxt = PH_INFO;
        end
      end
      PH_INFO: begin
        if (byte_idx_r == IDX_W'(INFO_BYTES - 1)) begin
          phase_nxt        = PH_LEN;
          byte_idx_nxt     = '0;
          length_accum_nxt = '0;
        end else begin
          byte_idx_nxt = byte_idx_r + 1'b1;
        end
      end
      PH_LEN: begin
        length_accum_nxt = length_accum_r | (WORD_W'(in_rx_byte) << lane_shift);
        if (byte_idx_r == IDX_W'(LEN_BYTES - 1)) begin
          byte_idx_nxt = '0;
          if (length_accum_nxt > WORD_W'(MAX_PAYLOAD)) begin
            phase_nxt = PH_HUNT;
            emit      = 1'b1;
            emit_kind = K_TOOLONG;
          end else begin
            pay_left_nxt = PAY_W'(length_accum_nxt);
            phase_nxt    = (length_accum_nxt == '0) ? PH_TAIL : PH_PAY;
          end
        end else begin
          byte_idx_nxt = byte_idx_r + 1'b1;
        end
      end
      PH_PAY: begin
        if (pay_left_r != '0) begin
          pay_left_nxt = pay_left_r - 1'b1;
        end
        if (pay_left_r <= PAY_W'(1)) begin
          phase_nxt = PH_TAIL;
        end
        emit       = 1'b1;
        emit_kind  = K_PAYLOAD;
        emit_pbyte = in_rx_byte;
      end
      PH_TAIL: begin
        // The closing byte is never rescanned as a head marker.
        phase_nxt    = PH_HUNT;
        byte_idx_nxt = '0;
        emit         = 1'b1;
        emit_kind    = (in_rx_byte == tail_marker_r) ? K_GOOD : K_BADTAIL;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  assign len_sat = (length_accum_nxt > WORD_W'(FLEN_MAX)) ? FLEN_MAX
                                                          : length_accum_nxt[FLEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_marker_r <= '0;
      magic_word_r  <= '0;
      tail_marker_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAD:  head_marker_r <= cfg_wdata[BYTE_W-1:0];
        CFG_MAGIC: magic_word_r  <= cfg_wdata;
        CFG_TAIL:  tail_marker_r <= cfg_wdata[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      byte_idx_r     <= '0;
      seq_hold_r     <= '0;
      cmd_hold_r     <= '0;
      length_accum_r <= '0;
      pay_left_r     <= '0;
    end else if (in_fire) begin
      phase_r        <= phase_nxt;
      byte_idx_r     <= byte_idx_nxt;
      seq_hold_r     <= seq_hold_nxt;
      cmd_hold_r     <= cmd_hold_nxt;
      length_accum_r <= length_accum_nxt;
      pay_left_r     <= pay_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; header fields read zero on a bad magic result.
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_kind_r  <= emit_kind;
      out_pbyte_r <= emit_pbyte;
      out_seq_r   <= emit_hdr ? seq_hold_nxt : '0;
      out_cmd_r   <= emit_hdr ? cmd_hold_nxt : '0;
      out_len_r   <= emit_hdr ? len_sat : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_payload_byte = out_pbyte_r;
  assign out_frame_seq    = out_seq_r;
  assign out_frame_cmd    = out_cmd_r;
  assign out_frame_length = out_len_r;

endmodule

`default_nettype wire
